FILE: src/bilinear_texture_scaler_defines.svh
// Assertion macros for the bilinear texture scaler checker.
// Used by bts_checker; expects clk and rst_n in scope.
`ifndef BILINEAR_TEXTURE_SCALER_DEFINES_SVH
`define BILINEAR_TEXTURE_SCALER_DEFINES_SVH

// Check a consequence in the cycle after an antecedent, outside reset.
`define BTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bts check failed");

// Check a condition on the cycle after reset is asserted.
`define BTS_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("bts reset check failed");

`endif

FILE: src/bts_pkg.sv
// Package for the bilinear texture scaler: constants, codes, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
package bts_pkg;
  localparam int CoordW    = 9;
  localparam int SizeW     = 10;
  localparam int PixW      = 32;
  localparam int BankAddrW = 16;
  localparam int QueueDepth = 4;
  localparam logic [SizeW-1:0] SrcDimMax = 10'd512;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic              cmd;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [PixW-1:0]   pixel;
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] y1;
    logic [CoordW-1:0] fx;
    logic [CoordW-1:0] fy;
  } entry_t;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] s);
    if (s == '0) return 10'd1;
    else if (s > SrcDimMax) return SrcDimMax;
    else return s;
  endfunction
endpackage

FILE: src/bilinear_texture_scaler.sv
// Top level of the bilinear texture scaler: front, queue, back.
// Depends on bts_pkg, bts_front, bts_queue, bts_back.
//
//  channel  dir  handshake          payload
//  in       in   in_tvalid/tready   tdata column,line,rgba; tuser command
//  out      out  out_tvalid/tready  tdata out_column,out_line,packed_rgba
//  cfg      in   cfg_we             cfg_index, cfg_wdata
//
// One request per cycle sustained while the out channel is not stalled; a sample result
// passes the front register, the queue, the frame store read registers and the blend register.
// Reset is synchronous on rst_n; the frame store is not cleared.
// A stalled out channel holds the back part; the queue absorbs the front.
`timescale 1ns / 1ps
module bilinear_texture_scaler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // column[8:0], line[17:9], red, green, blue, alpha
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_column[8:0], out_line[17:9], packed_rgba[49:18]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);
  logic            f_valid, f_ready, b_valid, b_ready;
  bts_pkg::entry_t f_entry, b_entry;
  logic [8:0]      o_col, o_row;
  logic [31:0]     o_pix;

  bts_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready),
    .in_cmd (in_tuser), .in_col (in_tdata[8:0]), .in_row (in_tdata[17:9]),
    .in_pixel (in_tdata[49:18]),
    .cfg_we, .cfg_index, .cfg_wdata,
    .q_valid (f_valid), .q_ready (f_ready), .q_entry (f_entry)
  );

  bts_queue u_queue (
    .clk, .rst_n,
    .push_valid (f_valid), .push_ready (f_ready), .push_entry (f_entry),
    .pop_valid (b_valid), .pop_ready (b_ready), .pop_entry (b_entry)
  );

  bts_back u_back (
    .clk, .rst_n,
    .q_valid (b_valid), .q_ready (b_ready), .q_entry (b_entry),
    .out_valid (out_tvalid), .out_ready (out_tready),
    .out_col (o_col), .out_row (o_row), .out_pixel (o_pix)
  );

  assign out_tdata = {6'd0, o_pix, o_row, o_col};
endmodule

FILE: src/bts_front.sv
// Front part: accepts requests, holds size registers, maps sample coordinates.
// Depends on bts_pkg.
`timescale 1ns / 1ps
module bts_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [bts_pkg::CoordW-1:0] in_col,
  input  logic [bts_pkg::CoordW-1:0] in_row,
  input  logic [bts_pkg::PixW-1:0]   in_pixel,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [bts_pkg::SizeW-1:0]  cfg_wdata,
  output logic                       q_valid,
  input  logic                       q_ready,
  output bts_pkg::entry_t            q_entry
);
  logic [bts_pkg::SizeW-1:0] width_r, height_r, size_w, size_h;
  logic                      fr_valid_r;
  bts_pkg::entry_t           fr_entry_r, fr_entry_nxt;
  logic [18:0]               qx, qy;
  logic [9:0]                nx, fxn, ny, fyn;

  assign size_w = bts_pkg::clamp_size(width_r);
  assign size_h = bts_pkg::clamp_size(height_r);
  assign in_ready = !fr_valid_r || q_ready;
  assign q_valid  = fr_valid_r;
  assign q_entry  = fr_entry_r;

  always_comb begin
    qx  = {10'd0, in_col} * {9'd0, size_w};
    qy  = {10'd0, in_row} * {9'd0, size_h};
    nx  = qx[18:9];
    ny  = qy[18:9];
    fxn = nx + 10'd1;
    fyn = ny + 10'd1;
    if (nx >= size_w) nx = size_w - 10'd1;
    if (fxn >= size_w) fxn = size_w - 10'd1;
    if (ny >= size_h) ny = size_h - 10'd1;
    if (fyn >= size_h) fyn = size_h - 10'd1;
    fr_entry_nxt.cmd   = in_cmd;
    fr_entry_nxt.col   = in_col;
    fr_entry_nxt.row   = in_row;
    fr_entry_nxt.pixel = in_pixel;
    fr_entry_nxt.x0    = nx[8:0];
    fr_entry_nxt.x1    = fxn[8:0];
    fr_entry_nxt.y0    = ny[8:0];
    fr_entry_nxt.y1    = fyn[8:0];
    fr_entry_nxt.fx    = qx[8:0];
    fr_entry_nxt.fy    = qy[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= bts_pkg::SrcDimMax;
      height_r   <= bts_pkg::SrcDimMax;
      fr_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == bts_pkg::REG_WIDTH) width_r <= cfg_wdata;
      if (cfg_we && cfg_index == bts_pkg::REG_HEIGHT) height_r <= cfg_wdata;
      if (in_ready) fr_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) fr_entry_r <= fr_entry_nxt;
  end
endmodule

FILE: src/bts_queue.sv
// Short queue of classified requests between the front and back parts.
// Depends on bts_pkg.
`timescale 1ns / 1ps
module bts_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  bts_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bts_pkg::entry_t pop_entry
);
  localparam int PtrW = $clog2(bts_pkg::QueueDepth);
  bts_pkg::entry_t mem_r [bts_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = count_r != (PtrW+1)'(bts_pkg::QueueDepth);
  assign pop_valid  = count_r != '0;
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PtrW'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + PtrW'(1);
      if (do_push && !do_pop) count_r <= count_r + (PtrW+1)'(1);
      else if (do_pop && !do_push) count_r <= count_r - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end
endmodule

FILE: src/bts_back.sv
// Back part: parity-banked frame store, bilinear blend, output register.
// Depends on bts_pkg.
`timescale 1ns / 1ps
module bts_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  bts_pkg::entry_t            q_entry,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bts_pkg::CoordW-1:0] out_col,
  output logic [bts_pkg::CoordW-1:0] out_row,
  output logic [bts_pkg::PixW-1:0]   out_pixel
);
  logic [bts_pkg::PixW-1:0] bank_mem [4][1 << bts_pkg::BankAddrW];
  logic [bts_pkg::PixW-1:0] rd_q [4];
  logic [bts_pkg::BankAddrW-1:0] rd_addr [4];
  logic adv, is_write, is_sample;
  logic [bts_pkg::CoordW-1:0] xsel [2], ysel [2];

  logic        s1_valid_r;
  logic [8:0]  s1_col_r, s1_row_r;
  logic [18:0] w_r [4];
  logic [1:0]  s1_sel_r [4];

  logic        s2_valid_r;
  logic [8:0]  s2_col_r, s2_row_r;
  logic [31:0] s2_pix_r, s2_pix_nxt;
  logic [9:0]  ifx, ify;

  assign adv       = !s2_valid_r || out_ready;
  assign q_ready   = adv;
  assign is_write  = q_valid && q_entry.cmd == bts_pkg::CMD_WRITE;
  assign is_sample = q_valid && q_entry.cmd == bts_pkg::CMD_SAMPLE;
  assign ifx       = 10'd512 - {1'b0, q_entry.fx};
  assign ify       = 10'd512 - {1'b0, q_entry.fy};

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      xsel[p] = (q_entry.x0[0] == p[0]) ? q_entry.x0 : q_entry.x1;
      ysel[p] = (q_entry.y0[0] == p[0]) ? q_entry.y0 : q_entry.y1;
    end
    for (int b = 0; b < 4; b++) begin
      rd_addr[b] = {ysel[b/2][8:1], xsel[b%2][8:1]};
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (adv && is_write && {q_entry.row[0], q_entry.col[0]} == b[1:0])
        bank_mem[b][{q_entry.row[8:1], q_entry.col[8:1]}] <= q_entry.pixel;
      if (adv) rd_q[b] <= bank_mem[b][rd_addr[b]];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col_r    <= q_entry.col;
      s1_row_r    <= q_entry.row;
      w_r[0]      <= {9'd0, ifx} * {9'd0, ify};
      w_r[1]      <= {10'd0, q_entry.fx} * {9'd0, ify};
      w_r[2]      <= {9'd0, ifx} * {10'd0, q_entry.fy};
      w_r[3]      <= {10'd0, q_entry.fx} * {10'd0, q_entry.fy};
      s1_sel_r[0] <= {q_entry.y0[0], q_entry.x0[0]};
      s1_sel_r[1] <= {q_entry.y0[0], q_entry.x1[0]};
      s1_sel_r[2] <= {q_entry.y1[0], q_entry.x0[0]};
      s1_sel_r[3] <= {q_entry.y1[0], q_entry.x1[0]};
      s2_col_r    <= s1_col_r;
      s2_row_r    <= s1_row_r;
      s2_pix_r    <= s2_pix_nxt;
    end
  end

  always_comb begin
    logic [26:0] sum;
    logic [31:0] px;
    s2_pix_nxt = '0;
    for (int c = 0; c < 4; c++) begin
      sum = '0;
      for (int k = 0; k < 4; k++) begin
        px  = rd_q[s1_sel_r[k]];
        sum = sum + {19'd0, px[c*8 +: 8]} * {8'd0, w_r[k]};
      end
      s2_pix_nxt[c*8 +: 8] = (sum[26:18] > 9'd255) ? 8'hFF : sum[25:18];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= is_sample;
      s2_valid_r <= s1_valid_r;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_col   = s2_col_r;
  assign out_row   = s2_row_r;
  assign out_pixel = s2_pix_r;
endmodule

FILE: src/bts_checker.sv
// Port-level checker for the bilinear texture scaler, bound to the top level.
// Depends on bilinear_texture_scaler_defines.svh.
`timescale 1ns / 1ps
`include "bilinear_texture_scaler_defines.svh"
module bts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  `BTS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `BTS_ASSERT_RST(a_rst_out_idle, !out_tvalid)
  `BTS_ASSERT_RST(a_rst_in_ready, in_tready)
endmodule

bind bilinear_texture_scaler bts_checker u_bts_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
